@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication does not hold");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication does not hold");

`endif

@@ rtl/edo_pkg.sv @@
// shared types and constants for the extent damage overlap block
package edo_pkg;

	localparam int unsigned MaxRangesDef = 16;
	localparam int unsigned DataW        = 64;

	typedef logic [DataW-1:0] word_t;

	// request codes
	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_EXT_BEGIN,
		ST_EXT_END,
		ST_WALK
	} state_t;

	// operand selection for the shared saturating adder
	typedef enum logic [1:0] {
		ADD_RANGE_END,
		ADD_EXT_BEGIN,
		ADD_EXT_END
	} add_sel_t;

	// sequencer controls
	typedef struct packed {
		add_sel_t add_sel;
		logic     tbl_wr;
		logic     rd_issue;
		logic     walk_done;
	} ctrl_t;

	// intersection pipeline result
	typedef struct packed {
		logic  valid;
		logic  hit;
		word_t offset;
		word_t length;
	} isect_res_t;

	// register byte address
	localparam logic [0:0] AddrStartOffset = 1'b0;

endpackage

@@ rtl/extent_damage_overlap_top.sv @@
// Extent damage overlap: a query makes two passes through the shared saturating adder,
// then reads the stored ranges, one table read per cycle, into the compare pipeline.
// One item at a time; busy stays high from the accepting edge to the edge that raises
// the last result, and a clear does not raise busy. Results appear on a one-cycle
// strobe from an output register; no stall.
// Asynchronous active-low reset empties the table and clears start_offset.
module extent_damage_overlap_top #(
	parameter int unsigned MAX_RANGES = edo_pkg::MaxRangesDef
) (
	input  logic           clk,
	input  logic           arst_n,
	// command channel
	input  logic           start,
	output logic           busy,
	input  logic [1:0]     req_type,
	input  edo_pkg::word_t item_offset,
	input  edo_pkg::word_t item_length,
	// result channel
	output logic           strobe,
	output logic           status,
	output logic           found,
	output edo_pkg::word_t overlap_offset,
	output edo_pkg::word_t overlap_length,
	output logic           last,
	// configuration port
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [0:0]     paddr,
	input  edo_pkg::word_t pwdata,
	output edo_pkg::word_t prdata,
	output logic           pready
);
	import edo_pkg::*;

	localparam int unsigned CntW  = $clog2(MAX_RANGES + 1);
	localparam int unsigned AddrW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	state_t          state_q, state_d;
	ctrl_t           ctrl;
	logic            accept;
	logic            full;
	word_t           start_offset_q;
	word_t           off_q, len_q;
	word_t           ext_beg_q, ext_end_q;
	logic [CntW-1:0] count_q, rd_idx_q;
	word_t           add_a, add_b, add_y;
	logic            tbl_rd_valid;
	word_t           tbl_rd_begin, tbl_rd_end;
	logic            isect_busy;
	isect_res_t      isect_res;
	logic            pend_v_q;
	word_t           pend_off_q, pend_len_q;

	logic            strobe_d, status_d, found_d, last_d;
	word_t           off_d, len_d;
	logic            strobe_q, status_q, found_q, last_q;
	word_t           res_off_q, res_len_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q >= CntW'(MAX_RANGES));

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == AddrStartOffset) ? start_offset_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == AddrStartOffset)) begin
			start_offset_q <= pwdata;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_t'(req_type))
						REQ_APPEND: state_d = ST_APPEND;
						REQ_QUERY:  state_d = ST_EXT_BEGIN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_APPEND:    state_d = ST_IDLE;
			ST_EXT_BEGIN: state_d = ST_EXT_END;
			ST_EXT_END:   state_d = ST_WALK;
			ST_WALK: begin
				if (ctrl.walk_done) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer outputs and next result beat
	always_comb begin
		ctrl.add_sel   = ADD_RANGE_END;
		ctrl.tbl_wr    = 1'b0;
		ctrl.rd_issue  = 1'b0;
		ctrl.walk_done = 1'b0;
		strobe_d       = 1'b0;
		status_d       = 1'b0;
		found_d        = 1'b0;
		off_d          = '0;
		len_d          = '0;
		last_d         = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_t'(req_type) == REQ_CLEAR)) strobe_d = 1'b1;
			end
			ST_APPEND: begin
				ctrl.tbl_wr = !full;
				strobe_d    = 1'b1;
				status_d    = full;
			end
			ST_EXT_BEGIN: ctrl.add_sel = ADD_EXT_BEGIN;
			ST_EXT_END:   ctrl.add_sel = ADD_EXT_END;
			ST_WALK: begin
				ctrl.rd_issue  = (rd_idx_q < count_q);
				ctrl.walk_done = (rd_idx_q == count_q) && !tbl_rd_valid && !isect_busy
					&& !isect_res.valid;
				if (isect_res.valid && isect_res.hit && pend_v_q) begin
					// a newer hit shows the pending one is not the last
					strobe_d = 1'b1;
					found_d  = 1'b1;
					off_d    = pend_off_q;
					len_d    = pend_len_q;
					last_d   = 1'b0;
				end else if (ctrl.walk_done) begin
					strobe_d = 1'b1;
					found_d  = pend_v_q;
					off_d    = pend_v_q ? pend_off_q : '0;
					len_d    = pend_v_q ? pend_len_q : '0;
				end
			end
			default: ;
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			off_q <= item_offset;
			len_q <= item_length;
		end
	end

	// shared adder operand selection
	always_comb begin
		case (ctrl.add_sel)
			ADD_EXT_BEGIN: begin
				add_a = start_offset_q;
				add_b = off_q;
			end
			ADD_EXT_END: begin
				add_a = ext_beg_q;
				add_b = len_q;
			end
			default: begin
				add_a = off_q;
				add_b = len_q;
			end
		endcase
	end

	edo_satadd u_add (
		.a (add_a),
		.b (add_b),
		.y (add_y)
	);

	// extent bounds
	always_ff @(posedge clk) begin
		if (state_q == ST_EXT_BEGIN) ext_beg_q <= add_y;
		if (state_q == ST_EXT_END)   ext_end_q <= add_y;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (req_t'(req_type) == REQ_CLEAR)) begin
			count_q <= '0;
		end else if (ctrl.tbl_wr) begin
			count_q <= count_q + 1'b1;
		end
	end

	// walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (state_q == ST_EXT_END) begin
			rd_idx_q <= '0;
		end else if (ctrl.rd_issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	edo_table #(
		.MAX_RANGES (MAX_RANGES),
		.ADDR_W     (AddrW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (ctrl.tbl_wr),
		.wr_addr  (count_q[AddrW-1:0]),
		.wr_begin (off_q),
		.wr_end   (add_y),
		.rd_en    (ctrl.rd_issue),
		.rd_addr  (rd_idx_q[AddrW-1:0]),
		.rd_valid (tbl_rd_valid),
		.rd_begin (tbl_rd_begin),
		.rd_end   (tbl_rd_end)
	);

	edo_isect u_isect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tbl_rd_valid),
		.rng_begin (tbl_rd_begin),
		.rng_end   (tbl_rd_end),
		.ext_begin (ext_beg_q),
		.ext_end   (ext_end_q),
		.pipe_busy (isect_busy),
		.res       (isect_res)
	);

	// pending hit, held back until the next hit or the end of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (state_q == ST_EXT_END || ctrl.walk_done) begin
			pend_v_q <= 1'b0;
		end else if (state_q == ST_WALK && isect_res.valid && isect_res.hit) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && isect_res.valid && isect_res.hit) begin
			pend_off_q <= isect_res.offset;
			pend_len_q <= isect_res.length;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (strobe_d) begin
			status_q  <= status_d;
			found_q   <= found_d;
			res_off_q <= off_d;
			res_len_q <= len_d;
			last_q    <= last_d;
		end
	end

	assign strobe         = strobe_q;
	assign status         = status_q;
	assign found          = found_q;
	assign overlap_offset = res_off_q;
	assign overlap_length = res_len_q;
	assign last           = last_q;

endmodule

@@ rtl/edo_table.sv @@
// bad range table: begin and end memories with registered read
module edo_table #(
	parameter int unsigned MAX_RANGES = edo_pkg::MaxRangesDef,
	parameter int unsigned ADDR_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  edo_pkg::word_t     wr_begin,
	input  edo_pkg::word_t     wr_end,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic               rd_valid,
	output edo_pkg::word_t     rd_begin,
	output edo_pkg::word_t     rd_end
);
	import edo_pkg::*;

	word_t beg_mem [MAX_RANGES];
	word_t fin_mem [MAX_RANGES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			beg_mem[wr_addr] <= wr_begin;
			fin_mem[wr_addr] <= wr_end;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_begin <= beg_mem[rd_addr];
			rd_end   <= fin_mem[rd_addr];
		end
	end

	// read data valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid <= 1'b0;
		end else begin
			rd_valid <= rd_en;
		end
	end

endmodule

@@ rtl/edo_satadd.sv @@
// shared 64-bit adder that saturates at all ones
module edo_satadd (
	input  edo_pkg::word_t a,
	input  edo_pkg::word_t b,
	output edo_pkg::word_t y
);
	import edo_pkg::*;

	logic [DataW:0] sum;

	// carry out means the sum passed the top of the range
	assign sum = {1'b0, a} + {1'b0, b};
	assign y   = sum[DataW] ? '1 : sum[DataW-1:0];

endmodule

@@ rtl/edo_isect.sv @@
// two-stage half-open interval intersection of a range with the extent
module edo_isect (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  edo_pkg::word_t      rng_begin,
	input  edo_pkg::word_t      rng_end,
	input  edo_pkg::word_t      ext_begin,
	input  edo_pkg::word_t      ext_end,
	output logic                pipe_busy,
	output edo_pkg::isect_res_t res
);
	import edo_pkg::*;

	logic           v_s1, v_s2;
	word_t          b_s1, e_s1;
	logic [DataW:0] diff;
	logic           hit_s2;
	word_t          off_s2, len_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: later begin, earlier end
	always_ff @(posedge clk) begin
		b_s1 <= (rng_begin > ext_begin) ? rng_begin : ext_begin;
		e_s1 <= (rng_end < ext_end) ? rng_end : ext_end;
	end

	// stage 2: length and non-empty test from one subtract
	assign diff = {1'b0, e_s1} - {1'b0, b_s1};

	always_ff @(posedge clk) begin
		hit_s2 <= !diff[DataW] && (diff[DataW-1:0] != '0);
		off_s2 <= b_s1;
		len_s2 <= diff[DataW-1:0];
	end

	assign pipe_busy  = v_s1;
	assign res.valid  = v_s2;
	assign res.hit    = hit_s2;
	assign res.offset = off_s2;
	assign res.length = len_s2;

endmodule

@@ rtl/edo_checker.sv @@
// port-level checker for the extent damage overlap block, bound to the top level
`include "assert_macros.svh"

module edo_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic [1:0]     req_type,
	input logic           strobe,
	input logic           status,
	input logic           found,
	input edo_pkg::word_t overlap_offset,
	input edo_pkg::word_t overlap_length,
	input logic           last
);
	import edo_pkg::*;

	// an overlap beat never reports a full table and always has bytes
	`ASSERT_IMPL(a_found_ok, clk, arst_n, strobe && found, !status && (overlap_length != '0))

	// a beat without overlap is the only beat of its item and carries zeros
	`ASSERT_IMPL(a_nofound_single, clk, arst_n, strobe && !found,
		last && (overlap_offset == '0) && (overlap_length == '0))

	// a full-table beat is a plain single beat
	`ASSERT_IMPL(a_full_beat, clk, arst_n, strobe && status, !found && last)

	// a query always keeps the block busy for the walk
	`ASSERT_NEXT(a_query_busy, clk, arst_n,
		start && !busy && (req_type == REQ_QUERY), busy && !strobe)

endmodule

bind extent_damage_overlap_top edo_checker u_edo_checker (.*);

@@ sim/extent_damage_overlap_top_tb.sv @@
// testbench for the extent damage overlap block: directed and random beats against a predictor
module extent_damage_overlap_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import edo_pkg::*;

	localparam int unsigned TableDepth  = MaxRangesDef;
	localparam int unsigned SettleWait  = 40;
	localparam int unsigned QuietLimit  = 2000;
	localparam int unsigned PhaseItems  = 25;
	localparam word_t       AllOnes     = '1;

	// one result beat as seen on the result ports
	typedef struct packed {
		logic  status;
		logic  found;
		word_t offset;
		word_t length;
		logic  last;
	} overlap_res_t;

	// bad range table predictor and queue of overlap results still due
	class damage_scoreboard;
		word_t        partition_start;
		word_t        bad_begin[TableDepth];
		word_t        bad_end[TableDepth];
		int unsigned  bad_count;
		overlap_res_t due[$];
		int unsigned  errors;

		function new();
			partition_start = '0;
			bad_count = 0;
			errors = 0;
		endfunction

		function word_t sat_sum(word_t a, word_t b);
			logic [DataW:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[DataW] ? AllOnes : s[DataW-1:0];
		endfunction

		// append one beat to the tail of the queue of results due
		function void add_due(overlap_res_t r);
			due = {due, r};
		endfunction

		// single closing beat with no overlap
		function overlap_res_t no_overlap(logic full);
			overlap_res_t r;
			r.status = full;
			r.found  = 1'b0;
			r.offset = '0;
			r.length = '0;
			r.last   = 1'b1;
			return r;
		endfunction

		// accepted command: update the table copy and queue its results
		function void note_request(req_t kind, word_t offs, word_t size);
			word_t        ext_lo, ext_hi, lo, hi;
			int unsigned  i, hits;
			overlap_res_t r;
			hits = 0;
			case (kind)
				REQ_CLEAR: begin
					bad_count = 0;
					add_due(no_overlap(1'b0));
				end
				REQ_APPEND: begin
					if (bad_count >= TableDepth) begin
						add_due(no_overlap(1'b1));
					end else begin
						bad_begin[bad_count] = offs;
						bad_end[bad_count]   = sat_sum(offs, size);
						bad_count++;
						add_due(no_overlap(1'b0));
					end
				end
				REQ_QUERY: begin
					ext_lo = sat_sum(partition_start, offs);
					ext_hi = sat_sum(ext_lo, size);
					for (i = 0; i < bad_count; i++) begin
						lo = (bad_begin[i] > ext_lo) ? bad_begin[i] : ext_lo;
						hi = (bad_end[i] < ext_hi) ? bad_end[i] : ext_hi;
						if (lo < hi) begin
							r.status = 1'b0;
							r.found  = 1'b1;
							r.offset = lo;
							r.length = hi - lo;
							r.last   = 1'b0;
							add_due(r);
							hits++;
						end
					end
					if (hits == 0) begin
						add_due(no_overlap(1'b0));
					end else begin
						due[due.size()-1].last = 1'b1;
					end
				end
				default: begin
				end
			endcase
		endfunction

		// compare one result beat with the oldest one due
		function void check_result(overlap_res_t got);
			overlap_res_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t unexpected result beat: status %0b found %0b offset %h length %h last %0b",
						$time, got.status, got.found, got.offset, got.length, got.last);
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status || got.found !== want.found ||
					got.offset !== want.offset || got.length !== want.length ||
					got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t result beat differs: expected status %0b found %0b offset %h length %h last %0b",
						$time, want.status, want.found, want.offset, want.length, want.last);
					$display("%0t                      actual status %0b found %0b offset %h length %h last %0b",
						$time, got.status, got.found, got.offset, got.length, got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = REQ_NONE;
	word_t       item_offset = '0;
	word_t       item_length = '0;
	logic        strobe;
	logic        status;
	logic        found;
	word_t       overlap_offset;
	word_t       overlap_length;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [0:0]  paddr = AddrStartOffset;
	word_t       pwdata = '0;
	word_t       prdata;
	logic        pready;

	damage_scoreboard sb = new();
	int unsigned      idle_pct = 0;
	int unsigned      quiet_cycles = 0;

	extent_damage_overlap_top DUT (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// send one command beat, with an optional gap first
	task automatic issue(input req_t kind, input word_t offs, input word_t size);
		logic took;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= kind;
		item_offset <= offs;
		item_length <= size;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
		sb.note_request(kind, offs, size);
	endtask

	// hold off until every result has come and the block has gone quiet
	task automatic settle();
		start <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SettleWait) @(posedge clk);
	endtask

	// register write over the configuration port
	task automatic program_partition_start(input word_t value);
		logic took;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrStartOffset;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			took = pready;
			@(posedge clk);
		end while (!took);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.partition_start = value;
	endtask

	// result beats and handshake activity, sampled mid-cycle
	always @(negedge clk) begin : result_monitor
		overlap_res_t got;
		quiet_cycles++;
		if (arst_n && start && busy === 1'b0)
			quiet_cycles = 0;
		if (arst_n && strobe === 1'b1) begin
			quiet_cycles = 0;
			got.status = status;
			got.found  = found;
			got.offset = overlap_offset;
			got.length = overlap_length;
			got.last   = last;
			sb.check_result(got);
		end
	end

	// watchdog on cycles with no beat moving
	initial begin : watchdog
		while (quiet_cycles < QuietLimit) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int unsigned p, n, roll;
		req_t        kind;
		word_t       offs, size, win, pos;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, edge ranges, full table, edge queries
		issue(REQ_CLEAR, '0, '0);
		issue(REQ_QUERY, '0, AllOnes);
		issue(REQ_APPEND, '0, '0);
		issue(REQ_APPEND, AllOnes - 64'd5, 64'd100);
		issue(REQ_APPEND, '0, AllOnes);
		issue(REQ_APPEND, 64'd100, 64'd50);
		for (n = 0; n < 12; n++)
			issue(REQ_APPEND, 64'd1000 + 64'(n) * 64'd200, 64'd100 + 64'(n));
		issue(REQ_APPEND, 64'd5, 64'd5);
		issue(REQ_QUERY, '0, AllOnes);
		issue(REQ_QUERY, 64'd120, '0);
		issue(REQ_QUERY, AllOnes - 64'd10, 64'd100);
		issue(REQ_QUERY, AllOnes, AllOnes);
		issue(REQ_NONE, rand_word(), rand_word());
		issue(REQ_CLEAR, AllOnes, AllOnes);
		settle();

		// random phases, each with its own partition start and sender gaps
		for (p = 0; p < 4; p++) begin
			case (p)
				0: program_partition_start(rand_word());
				1: program_partition_start(AllOnes);
				2: program_partition_start('0);
				default: program_partition_start(word_t'($urandom_range(1, 1 << 20)));
			endcase
			case (p)
				1: idle_pct = 61;
				3: idle_pct = 36;
				default: idle_pct = 0;
			endcase
			// ranges and queries cluster in a window just above the partition start, or near the top when it lies too high
			if (sb.partition_start > AllOnes - 64'd1048576)
				win = AllOnes - 64'd8191;
			else
				win = sb.partition_start;
			for (n = 0; n < PhaseItems; n++) begin
				if ($urandom_range(19) == 0)
					settle();
				roll = $urandom_range(99);
				if (roll < 5)
					kind = REQ_CLEAR;
				else if (roll < 46)
					kind = REQ_APPEND;
				else if (roll < 95)
					kind = REQ_QUERY;
				else
					kind = REQ_NONE;
				if ($urandom_range(99) < 12) begin
					offs = rand_word();
					size = rand_word();
				end else begin
					pos  = win + word_t'($urandom_range(0, 4095));
					size = word_t'($urandom_range(0, 600));
					if ($urandom_range(15) == 0)
						size = AllOnes - word_t'($urandom_range(0, 3));
					offs = (kind == REQ_QUERY) ? pos - sb.partition_start : pos;
				end
				issue(kind, offs, size);
			end
			settle();
		end

		if (sb.errors == 0 && sb.due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
